// ===== rtl/metasprite_table_engine_top_assert.svh =====
// Assertion macros for the metasprite table engine checker.
`ifndef METASPRITE_TABLE_ENGINE_TOP_ASSERT_SVH
`define METASPRITE_TABLE_ENGINE_TOP_ASSERT_SVH

// Whole property given by the caller.
`define MSTE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication.
`define MSTE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MSTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mste_pkg.sv =====
// Shared types and constants of the metasprite table engine.
package mste_pkg;

    localparam int NUM_CELLS    = 16;
    localparam int SPR_PER_SLOT = 4;
    localparam int HALF_SIZE    = 8;
    localparam int HIT_BIAS     = 16;
    localparam int HIT_RANGE    = 32;
    localparam int SLOT_W       = 5;
    localparam int INDEX_W      = 6;
    localparam int CMD_W        = 3;
    localparam int BYTE_W       = 8;
    localparam int TDATA_W      = 40;

    localparam logic [BYTE_W-1:0] OFFSCREEN_RESET = 8'd240;
    localparam logic [BYTE_W-1:0] ANIM_MASK       = 8'h04;

    localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SETTILE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ANIMATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MOVE    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_HIT     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd6;

    // Command token walking down the cell row, with its result so far.
    typedef struct packed {
        logic               valid;
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] index;
        logic [BYTE_W-1:0]  pos_x;
        logic [BYTE_W-1:0]  pos_y;
        logic [BYTE_W-1:0]  tile_number;
        logic [BYTE_W-1:0]  attribute;
        logic               done;
        logic [SLOT_W-1:0]  slot;
        logic               hit;
        logic [BYTE_W-1:0]  sprite_y;
        logic [BYTE_W-1:0]  sprite_tile;
        logic [BYTE_W-1:0]  sprite_attr;
        logic [BYTE_W-1:0]  sprite_x;
    } mste_tok_t;

endpackage

// ===== rtl/mste_cell.sv =====
// One slot cell: holds the four sprites of a metasprite slot and passes the token on.
module mste_cell
    import mste_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [3:0]           cell_id,
    input  logic                 slot_en,
    input  logic [BYTE_W-1:0]    offscreen,
    input  mste_tok_t            tok_in,
    output mste_tok_t            tok_out
);

    logic [BYTE_W-1:0] y_reg    [SPR_PER_SLOT];
    logic [BYTE_W-1:0] tile_reg [SPR_PER_SLOT];
    logic [BYTE_W-1:0] attr_reg [SPR_PER_SLOT];
    logic [BYTE_W-1:0] x_reg    [SPR_PER_SLOT];
    logic [BYTE_W-1:0] y_next    [SPR_PER_SLOT];
    logic [BYTE_W-1:0] tile_next [SPR_PER_SLOT];
    logic [BYTE_W-1:0] attr_next [SPR_PER_SLOT];
    logic [BYTE_W-1:0] x_next    [SPR_PER_SLOT];
    mste_tok_t         tok_reg;
    mste_tok_t         tok_next;

    logic [1:0]        sel;
    logic [BYTE_W-1:0] dy;
    logic [BYTE_W-1:0] dx;
    logic [BYTE_W-1:0] pl_x;
    logic [BYTE_W-1:0] pl_y;
    logic              slot_match;
    logic              spr_match;
    logic              do_place;
    logic              do_tiles;
    logic              do_anim;

    assign sel        = tok_in.index[5:4];
    assign slot_match = slot_en && (tok_in.index == {2'b00, cell_id});
    assign spr_match  = tok_in.index[3:0] == cell_id;
    assign dy         = tok_in.pos_y + BYTE_W'(HIT_BIAS) - y_reg[sel];
    assign dx         = tok_in.pos_x + BYTE_W'(HIT_BIAS) - x_reg[sel];

    always_comb
    begin
        tok_next  = tok_in;
        y_next    = y_reg;
        tile_next = tile_reg;
        attr_next = attr_reg;
        x_next    = x_reg;
        do_place  = 1'b0;
        do_tiles  = 1'b0;
        do_anim   = 1'b0;
        pl_x      = tok_in.pos_x;
        pl_y      = tok_in.pos_y;
        if (tok_in.valid)
        begin
            case (tok_in.cmd)
                CMD_APPEND:
                begin
                    if (!tok_in.done && slot_en && y_reg[0] == offscreen)
                    begin
                        do_place      = 1'b1;
                        do_tiles      = 1'b1;
                        tok_next.done = 1'b1;
                        tok_next.slot = {1'b0, cell_id};
                    end
                end
                CMD_REMOVE:
                begin
                    do_place = slot_match;
                    pl_x     = offscreen;
                    pl_y     = offscreen;
                end
                CMD_SETTILE: do_tiles = slot_match;
                CMD_ANIMATE: do_anim  = slot_match;
                CMD_MOVE:    do_place = slot_match;
                CMD_HIT:
                begin
                    if (spr_match)
                        tok_next.hit = (dy < BYTE_W'(HIT_RANGE)) && (dx < BYTE_W'(HIT_RANGE));
                end
                CMD_READ:
                begin
                    if (spr_match)
                    begin
                        tok_next.sprite_y    = y_reg[sel];
                        tok_next.sprite_tile = tile_reg[sel];
                        tok_next.sprite_attr = attr_reg[sel];
                        tok_next.sprite_x    = x_reg[sel];
                    end
                end
                default: ;
            endcase
        end
        for (int k = 0; k < SPR_PER_SLOT; k++)
        begin
            if (do_place)
            begin
                y_next[k] = (k >= 2) ? pl_y + BYTE_W'(HALF_SIZE) : pl_y;
                x_next[k] = (k % 2 == 1) ? pl_x + BYTE_W'(HALF_SIZE) : pl_x;
            end
            if (do_tiles)
            begin
                tile_next[k] = tok_in.tile_number + BYTE_W'(k);
                attr_next[k] = tok_in.attribute;
            end
            if (do_anim)
                tile_next[k] = tile_reg[k] ^ ANIM_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
            for (int k = 0; k < SPR_PER_SLOT; k++)
            begin
                y_reg[k]    <= (k >= 2) ? OFFSCREEN_RESET + BYTE_W'(HALF_SIZE)
                                        : OFFSCREEN_RESET;
                x_reg[k]    <= (k % 2 == 1) ? OFFSCREEN_RESET + BYTE_W'(HALF_SIZE)
                                            : OFFSCREEN_RESET;
                tile_reg[k] <= '0;
                attr_reg[k] <= '0;
            end
        end
        else
        begin
            tok_reg  <= tok_next;
            y_reg    <= y_next;
            tile_reg <= tile_next;
            attr_reg <= attr_next;
            x_reg    <= x_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/metasprite_table_engine_top.sv =====
// Top level of the metasprite table engine: cell row, result holding and output register.
//
//  channel  | dir | handshake               | payload
//  s_axis   | in  | s_axis_tvalid/tready    | tuser: cmd; tdata: index,pos_x,pos_y,tile,attr
//  m_axis   | out | m_axis_tvalid/tready    | tdata: slot,hit,sprite_y,tile,attr,sprite_x
//  cfg      | in  | cfg_valid/cfg_ready     | cfg_data: offscreen_value
//
// A command walks the row of 16 slot cells, one cell per cycle; its result then
// passes the holding register and the output register, and the next command is
// taken only once the previous result has left the holding register.
// Reset puts every sprite offscreen at once; no clearing pass.
// An output stall does not hold the row; a second result waits only if the
// first is still in the output register.
module metasprite_table_engine_top
    import mste_pkg::*;
#(
    parameter int NUM_SLOTS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,  // index[5:0], pos_x, pos_y, tile_number, attribute
    input  logic [CMD_W-1:0]   s_axis_tuser,  // cmd
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,  // slot[4:0], hit, sprite_y, tile, attr, sprite_x
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [BYTE_W-1:0]  cfg_data
);

    mste_tok_t         chain [NUM_CELLS+1];
    mste_tok_t         head_tok;
    mste_tok_t         pend_reg;
    logic              pend_valid_reg;
    logic              busy_reg;
    logic              out_valid_reg;
    logic [TDATA_W-1:0] out_data_reg;
    logic [BYTE_W-1:0] offscreen_reg;
    logic              in_xfer;
    logic              pend_to_out;

    assign s_axis_tready = !busy_reg && !pend_valid_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign pend_to_out   = pend_valid_reg && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        head_tok             = '0;
        head_tok.valid       = in_xfer;
        head_tok.cmd         = s_axis_tuser;
        head_tok.index       = s_axis_tdata[5:0];
        head_tok.pos_x       = s_axis_tdata[13:6];
        head_tok.pos_y       = s_axis_tdata[21:14];
        head_tok.tile_number = s_axis_tdata[29:22];
        head_tok.attribute   = s_axis_tdata[37:30];
        head_tok.slot        = (s_axis_tuser == CMD_APPEND) ? SLOT_W'(NUM_SLOTS) : '0;
    end

    assign chain[0] = head_tok;

    for (genvar s = 0; s < NUM_CELLS; s++)
    begin : g_cell
        mste_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_id   (4'(s)),
            .slot_en   (s < NUM_SLOTS),
            .offscreen (offscreen_reg),
            .tok_in    (chain[s]),
            .tok_out   (chain[s+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offscreen_reg  <= OFFSCREEN_RESET;
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                offscreen_reg <= cfg_data;
            if (in_xfer)
                busy_reg <= 1'b1;
            else if (chain[NUM_CELLS].valid)
                busy_reg <= 1'b0;
            if (chain[NUM_CELLS].valid)
                pend_valid_reg <= 1'b1;
            else if (pend_to_out)
                pend_valid_reg <= 1'b0;
            if (pend_to_out)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain[NUM_CELLS].valid)
            pend_reg <= chain[NUM_CELLS];
        if (pend_to_out)
            out_data_reg <= {2'b00, pend_reg.sprite_x, pend_reg.sprite_attr,
                             pend_reg.sprite_tile, pend_reg.sprite_y, pend_reg.hit,
                             pend_reg.slot};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== rtl/mste_checker.sv =====
// Port-level checker for the metasprite table engine, bound to the top level.
`include "metasprite_table_engine_top_assert.svh"

module mste_checker
    import mste_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata
);

    logic out_stall;
    logic in_xfer;
    logic hit_out;
    logic others_zero;

    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign in_xfer     = s_axis_tvalid && s_axis_tready;
    assign hit_out     = m_axis_tvalid && m_axis_tdata[5];
    assign others_zero = (m_axis_tdata[39:6] == '0) && (m_axis_tdata[4:0] == '0);

    `MSTE_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid, "output dropped while stalled")
    `MSTE_ASSERT_NEXT(a_one_in_flight, in_xfer, !s_axis_tready, "second command while busy")
    `MSTE_ASSERT_IMPL(a_slot_range, m_axis_tvalid, m_axis_tdata[4:0] <= 5'd16, "slot out of range")
    `MSTE_ASSERT_IMPL(a_hit_alone, hit_out, others_zero, "hit result carries other fields")

endmodule

bind metasprite_table_engine_top mste_checker u_mste_checker (.*);

// ===== tb/sv/tb_metasprite_table_engine_top.sv =====
// Self-checking testbench for the metasprite table engine top level.
`timescale 1ns / 100ps

module tb_metasprite_table_engine_top;
    import mste_pkg::*;

    localparam int TABLE_SLOTS   = 16;
    localparam int SPRITE_TOTAL  = 64;
    localparam int GROUP_STEP    = 16;
    localparam int PIPE_LATENCY  = 18;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic [BYTE_W-1:0] spr_y;
        logic [BYTE_W-1:0] spr_tile;
        logic [BYTE_W-1:0] spr_attr;
        logic [BYTE_W-1:0] spr_x;
    } table_result_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;   // index[5:0], pos_x, pos_y, tile_number, attribute
    logic [CMD_W-1:0]   s_axis_tuser;   // cmd
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;   // slot[4:0], hit, sprite_y, tile, attr, sprite_x
    logic               cfg_valid;
    logic               cfg_ready;
    logic [BYTE_W-1:0]  cfg_data;

    // shadow copy of the sprite table
    logic [BYTE_W-1:0] shadow_y    [SPRITE_TOTAL];
    logic [BYTE_W-1:0] shadow_tile [SPRITE_TOTAL];
    logic [BYTE_W-1:0] shadow_attr [SPRITE_TOTAL];
    logic [BYTE_W-1:0] shadow_x    [SPRITE_TOTAL];
    logic [BYTE_W-1:0] offscreen_q;

    table_result_t pending_results[$];
    table_result_t got_result;
    table_result_t want_result;

    int  mismatch_count;
    int  results_checked;
    int  cmd_count [8];
    int  full_appends;
    int  hit_count;
    int  cfg_writes;
    int  burst_left;
    bit  driving_valid;
    int  stall_mode;
    int  stall_len;

    metasprite_table_engine_top #(
        .NUM_SLOTS(TABLE_SLOTS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void place_group(int s, logic [BYTE_W-1:0] x, logic [BYTE_W-1:0] y);
        logic [BYTE_W-1:0] x2;
        logic [BYTE_W-1:0] y2;
        x2 = x + 8'(HALF_SIZE);
        y2 = y + 8'(HALF_SIZE);
        shadow_y[s]                  = y;
        shadow_x[s]                  = x;
        shadow_y[s + GROUP_STEP]     = y;
        shadow_x[s + GROUP_STEP]     = x2;
        shadow_y[s + 2 * GROUP_STEP] = y2;
        shadow_x[s + 2 * GROUP_STEP] = x;
        shadow_y[s + 3 * GROUP_STEP] = y2;
        shadow_x[s + 3 * GROUP_STEP] = x2;
    endfunction

    function automatic void set_group_tiles(int s, logic [BYTE_W-1:0] t, logic [BYTE_W-1:0] a);
        for (int k = 0; k < SPR_PER_SLOT; k++)
        begin
            shadow_tile[s + k * GROUP_STEP] = t + 8'(k);
            shadow_attr[s + k * GROUP_STEP] = a;
        end
    endfunction

    function automatic table_result_t run_table_command(
        logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx, logic [BYTE_W-1:0] px,
        logic [BYTE_W-1:0] py, logic [BYTE_W-1:0] tn, logic [BYTE_W-1:0] at);
        table_result_t     r;
        bit                slot_ok;
        int                s;
        logic [BYTE_W-1:0] dy;
        logic [BYTE_W-1:0] dx;
        r = '0;
        slot_ok = idx < TABLE_SLOTS;
        cmd_count[cmd]++;
        case (cmd)
            CMD_APPEND:
            begin
                for (s = 0; s < TABLE_SLOTS; s++)
                    if (shadow_y[s] == offscreen_q)
                        break;
                if (s < TABLE_SLOTS)
                begin
                    place_group(s, px, py);
                    set_group_tiles(s, tn, at);
                end
                else
                    full_appends++;
                r.slot = SLOT_W'(s);
            end
            CMD_REMOVE:
                if (slot_ok)
                    place_group(int'(idx), offscreen_q, offscreen_q);
            CMD_SETTILE:
                if (slot_ok)
                    set_group_tiles(int'(idx), tn, at);
            CMD_ANIMATE:
                if (slot_ok)
                    for (int k = 0; k < SPR_PER_SLOT; k++)
                        shadow_tile[idx + k * GROUP_STEP] ^= ANIM_MASK;
            CMD_MOVE:
                if (slot_ok)
                    place_group(int'(idx), px, py);
            CMD_HIT:
            begin
                dy = py + 8'(HIT_BIAS) - shadow_y[idx];
                dx = px + 8'(HIT_BIAS) - shadow_x[idx];
                r.hit = (dy < HIT_RANGE) && (dx < HIT_RANGE);
                if (r.hit)
                    hit_count++;
            end
            CMD_READ:
            begin
                r.spr_y    = shadow_y[idx];
                r.spr_tile = shadow_tile[idx];
                r.spr_attr = shadow_attr[idx];
                r.spr_x    = shadow_x[idx];
            end
            default:
                ;
        endcase
        return r;
    endfunction

    // one command transfer; called and returns at a falling edge
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                            input logic [BYTE_W-1:0] px, input logic [BYTE_W-1:0] py,
                            input logic [BYTE_W-1:0] tn, input logic [BYTE_W-1:0] at);
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, at, tn, py, px, idx};
        s_axis_tvalid <= 1'b1;
        driving_valid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results.push_back(run_table_command(cmd, idx, px, py, tn, at));
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_axis_tvalid <= 1'b0;
            driving_valid = 1'b0;
            repeat ($urandom_range(1, 8))
                @(negedge clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic drain_results();
        if (driving_valid)
        begin
            s_axis_tvalid <= 1'b0;
            driving_valid = 1'b0;
            @(negedge clk);
        end
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_offscreen(input logic [BYTE_W-1:0] value);
        drain_results();
        repeat (4)
            @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        offscreen_q = value;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_contents();
        send_cmd(CMD_READ, 6'd0,  8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_READ, 6'd16, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(CMD_READ, 6'd32, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_READ, 6'd63, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_HIT,  6'd63, 8'd248, 8'd248, 8'h00, 8'h00);
    endtask

    task automatic test_command_set();
        send_cmd(CMD_APPEND,  6'd63, 8'd100, 8'd100, 8'hFE, 8'hA5);
        send_cmd(CMD_READ,    6'd48, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_ANIMATE, 6'd0,  8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_READ,    6'd16, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_SETTILE, 6'd0,  8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_MOVE,    6'd0,  8'd252, 8'd250, 8'h00, 8'h00);
        send_cmd(CMD_READ,    6'd48, 8'h00, 8'h00, 8'h00, 8'h00);
        // window edges with wraparound
        send_cmd(CMD_HIT,     6'd0,  8'd236, 8'd234, 8'h00, 8'h00);
        send_cmd(CMD_HIT,     6'd0,  8'd11,  8'd9,   8'h00, 8'h00);
        send_cmd(CMD_HIT,     6'd0,  8'd12,  8'd10,  8'h00, 8'h00);
        send_cmd(CMD_HIT,     6'd0,  8'd235, 8'd233, 8'h00, 8'h00);
        send_cmd(CMD_REMOVE,  6'd0,  8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_READ,    6'd0,  8'h00, 8'h00, 8'h00, 8'h00);
        // slot index past the table
        send_cmd(CMD_REMOVE,  6'd16, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_MOVE,    6'd63, 8'h11, 8'h22, 8'h00, 8'h00);
        send_cmd(CMD_UNUSED,  6'd63, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(CMD_APPEND,  6'd0,  8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_cmd(CMD_READ,    6'd63, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_offscreen_extremes();
        write_offscreen(8'd0);
        send_cmd(CMD_APPEND, 6'd0,  8'h12, 8'h34, 8'h56, 8'h78);
        send_cmd(CMD_REMOVE, 6'd5,  8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_APPEND, 6'd0,  8'h00, 8'h00, 8'h01, 8'h02);
        send_cmd(CMD_APPEND, 6'd0,  8'h40, 8'h50, 8'h03, 8'h04);
        send_cmd(CMD_READ,   6'd21, 8'h00, 8'h00, 8'h00, 8'h00);
        write_offscreen(8'd255);
        send_cmd(CMD_APPEND, 6'd0,  8'h20, 8'h30, 8'h40, 8'h50);
        send_cmd(CMD_REMOVE, 6'd15, 8'h00, 8'h00, 8'h00, 8'h00);
        send_cmd(CMD_READ,   6'd63, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_random_traffic(input int n_items, input int append_pct);
        int                r;
        logic [CMD_W-1:0]  cmd;
        logic [INDEX_W-1:0] idx;
        logic [BYTE_W-1:0] px;
        logic [BYTE_W-1:0] py;
        for (int n = 0; n < n_items; n++)
        begin
            r   = $urandom_range(0, 99);
            idx = INDEX_W'($urandom_range(0, 63));
            px  = 8'($urandom_range(0, 255));
            py  = 8'($urandom_range(0, 255));
            if (r < append_pct)
                cmd = CMD_APPEND;
            else if (r < append_pct + 18)
                cmd = CMD_REMOVE;
            else if (r < append_pct + 26)
                cmd = CMD_SETTILE;
            else if (r < append_pct + 34)
                cmd = CMD_ANIMATE;
            else if (r < append_pct + 44)
                cmd = CMD_MOVE;
            else if (r < append_pct + 58)
                cmd = CMD_HIT;
            else if (r < 98)
                cmd = CMD_READ;
            else
                cmd = CMD_UNUSED;
            if (cmd inside {CMD_REMOVE, CMD_SETTILE, CMD_ANIMATE, CMD_MOVE}
                && $urandom_range(0, 9) != 0)
                idx = INDEX_W'($urandom_range(0, TABLE_SLOTS - 1));
            if (cmd == CMD_APPEND && $urandom_range(0, 9) == 0)
                py = offscreen_q;
            if (cmd == CMD_HIT && $urandom_range(0, 3) != 0)
            begin
                px = shadow_x[idx] + 8'($urandom_range(0, 40)) - 8'd20;
                py = shadow_y[idx] + 8'($urandom_range(0, 40)) - 8'd20;
            end
            send_cmd(cmd, idx, px, py, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_result = {m_axis_tdata[4:0], m_axis_tdata[5], m_axis_tdata[13:6],
                          m_axis_tdata[21:14], m_axis_tdata[29:22], m_axis_tdata[37:30]};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected result transfer %h", $realtime, m_axis_tdata);
            end
            else
            begin
                want_result = pending_results.pop_front();
                results_checked++;
                if (got_result.slot !== want_result.slot || got_result.hit !== want_result.hit
                    || got_result.spr_y !== want_result.spr_y
                    || got_result.spr_tile !== want_result.spr_tile
                    || got_result.spr_attr !== want_result.spr_attr
                    || got_result.spr_x !== want_result.spr_x)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: result %0d mismatch", $realtime, results_checked);
                        $display("  exp slot=%0d hit=%0d y=%h t=%h a=%h x=%h",
                                 want_result.slot, want_result.hit, want_result.spr_y,
                                 want_result.spr_tile, want_result.spr_attr, want_result.spr_x);
                        $display("  got slot=%0d hit=%0d y=%h t=%h a=%h x=%h",
                                 got_result.slot, got_result.hit, got_result.spr_y,
                                 got_result.spr_tile, got_result.spr_attr, got_result.spr_x);
                    end
                end
            end
        end
    end

    // output backpressure
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall_mode = $urandom_range(0, 3);
            stall_len  = $urandom_range(10, 60);
            for (int i = 0; i < stall_len; i++)
            begin
                @(negedge clk);
                case (stall_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= (i % 4 == 3);
                    default: m_axis_tready <= (i % 40 < 25);
                endcase
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        driving_valid = 1'b0;
        burst_left    = 0;
        offscreen_q   = OFFSCREEN_RESET;
        for (int i = 0; i < SPRITE_TOTAL; i++)
        begin
            shadow_tile[i] = '0;
            shadow_attr[i] = '0;
        end
        for (int s = 0; s < GROUP_STEP; s++)
            place_group(s, OFFSCREEN_RESET, OFFSCREEN_RESET);

        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_contents();
        test_command_set();
        test_offscreen_extremes();
        write_offscreen(OFFSCREEN_RESET);
        test_random_traffic(85, 30);
        write_offscreen(8'd255);
        test_random_traffic(85, 40);
        write_offscreen(8'd0);
        test_random_traffic(85, 25);
        write_offscreen(8'($urandom_range(0, 255)));
        test_random_traffic(85, 35);
        write_offscreen(8'($urandom_range(0, 255)));
        test_random_traffic(85, 45);
        write_offscreen(OFFSCREEN_RESET);
        test_random_traffic(85, 20);

        drain_results();
        repeat (PIPE_LATENCY * 2)
            @(posedge clk);
        mismatch_count += pending_results.size();

        $display("Commands: append %0d (table full %0d), remove %0d, set tile %0d, animate %0d",
                 cmd_count[CMD_APPEND], full_appends, cmd_count[CMD_REMOVE],
                 cmd_count[CMD_SETTILE], cmd_count[CMD_ANIMATE]);
        $display("move %0d, hit %0d (%0d hits), read %0d, unused %0d, cfg %0d, checked %0d",
                 cmd_count[CMD_MOVE], cmd_count[CMD_HIT], hit_count, cmd_count[CMD_READ],
                 cmd_count[CMD_UNUSED], cfg_writes, results_checked);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
